/* rtl/skq_pkg.sv */
package skq_pkg;

   localparam int KEY_W   = 64;
   localparam int TAG_W   = 32;
   localparam int COUNT_W = 7;

   typedef enum logic [2:0] {
      OP_INSERT   = 3'd0,
      OP_REMOVE   = 3'd1,
      OP_FIND     = 3'd2,
      OP_POP_HEAD = 3'd3,
      OP_POP_TAIL = 3'd4
   } req_op_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_MISS = 2'd1,
      STATUS_FULL = 2'd2
   } status_type;

   typedef enum logic {
      FSM_IDLE = 1'b0,
      FSM_EXEC = 1'b1
   } fsm_type;

   typedef struct packed {
      logic [2:0]              req_type;
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } req_data_type;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] out_key;
      logic [TAG_W-1:0]        out_tag;
      logic [COUNT_W-1:0]      count;
   } rsp_data_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key;
      logic [TAG_W-1:0]        tag;
   } entry_type;

   // strobes from the sequencer to every cell
   typedef struct packed {
      logic cap;   // capture compare flags against the incoming transaction
      logic ins;   // insert commits
      logic rem;   // remove commits (match found)
      logic pop;   // pop head commits
      logic find;  // select last equal key rather than tail
   } ctrl_type;

endpackage

/* rtl/skq_cell.sv */
module skq_cell (
   input  logic                 clock,
   input  skq_pkg::ctrl_type    ctrl,
   input  logic                 descending,
   input  logic                 occ,
   input  logic                 right_occ,
   input  logic                 left_p,
   input  logic                 right_keq,
   input  skq_pkg::entry_type   cmp_entry,
   input  skq_pkg::entry_type   ins_entry,
   input  skq_pkg::entry_type   left_entry,
   input  skq_pkg::entry_type   right_entry,
   output skq_pkg::entry_type   entry,
   output logic                 p_o,
   output logic                 keq_o,
   output logic                 hit_o,
   output logic                 sel_o
);
   import skq_pkg::*;

   entry_type entry_ff, entry_in;
   logic      p_ff, p_in;
   logic      keq_ff, keq_in;
   logic      teq_ff, teq_in;
   logic      key_lt, key_eq, tag_lt, tag_eq, lt, gt;

   always_comb begin
      key_lt = $signed(entry_ff.key) < $signed(cmp_entry.key);
      key_eq = entry_ff.key == cmp_entry.key;
      tag_lt = entry_ff.tag < cmp_entry.tag;
      tag_eq = entry_ff.tag == cmp_entry.tag;
      lt     = key_lt | (key_eq & tag_lt);
      gt     = ~lt & ~(key_eq & tag_eq);
      p_in   = occ & (descending ? gt : lt);
      keq_in = occ & key_eq;
      teq_in = tag_eq;
   end

   always_ff @(posedge clock) begin
      if (ctrl.cap) begin
         p_ff   <= p_in;
         keq_ff <= keq_in;
         teq_ff <= teq_in;
      end
   end

   // occupied entries that precede the request form a prefix of the row
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.ins && !p_ff) begin
         entry_in = left_p ? ins_entry : left_entry;
      end else if (ctrl.rem && !p_ff) begin
         entry_in = right_entry;
      end else if (ctrl.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign p_o   = p_ff;
   assign keq_o = keq_ff;
   assign hit_o = ~p_ff & left_p & keq_ff & teq_ff;
   assign sel_o = ctrl.find ? (keq_ff & ~right_keq) : (occ & ~right_occ);

endmodule

/* rtl/sorted_key_tag_queue.sv */
// Sorted key/tag queue: an ordered multiset of (key, tag) entries held in a
// row of cells, kept sorted by signed key then unsigned tag.
// Request channel (req_valid/req_stall/req_data): insert, remove an exact
// (key, tag), find a key, pop head or pop tail. Every transaction gives one
// response on rsp_valid/rsp_stall/rsp_data with status, key, tag and count.
// csr_wr_en/csr_wr_data set the descending order; the write only lands while
// the queue is empty.
// Timing: a request is taken in the idle cycle, every cell compares against
// it at that edge, and the execute state after it commits the shift across
// the row and loads the response register, which raises rsp_valid; no new
// request is taken until that commit, as req_stall is high while executing.
// The response register keeps its transaction while rsp_stall is high; the
// commit waits in the execute cycle and req_stall stays high until it goes.
// Reset empties the queue, clears the response and selects ascending order;
// entry contents are left as they are and read only below the fill count.
module sorted_key_tag_queue #(
   parameter int CAPACITY = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  skq_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output skq_pkg::rsp_data_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import skq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   fsm_type                 state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    desc_ff, desc_in;
   req_data_type            req_ff;
   rsp_data_type            rsp_data_ff, rsp_data_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    accept, commit;
   ctrl_type                ctrl;
   entry_type               ins_entry;

   entry_type               cell_entry [CAPACITY];
   logic [CAPACITY-1:0]     occ, p, keq, hit, sel;

   logic                    full, empty, hit_any, sel_any;
   entry_type               sel_entry;

   // ---------------------------------------------------------------- control
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (req_valid) state_in = FSM_EXEC;
         FSM_EXEC: if (commit)    state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      commit    = 1'b0;
      unique case (state_ff)
         FSM_IDLE: req_stall = 1'b0;
         FSM_EXEC: commit    = ~(rsp_valid_ff & rsp_stall);
         default:  req_stall = 1'b1;
      endcase
   end

   assign accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
   end

   assign full      = count_ff == CNT_W'(CAPACITY);
   assign empty     = count_ff == '0;
   assign ins_entry = '{key: req_ff.key, tag: req_ff.tag};

   always_comb begin
      ctrl.cap  = accept;
      ctrl.ins  = commit & (req_ff.req_type == OP_INSERT) & ~full;
      ctrl.rem  = commit & (req_ff.req_type == OP_REMOVE) & hit_any;
      ctrl.pop  = commit & (req_ff.req_type == OP_POP_HEAD) & ~empty;
      ctrl.find = req_ff.req_type == OP_FIND;
   end

   // ---------------------------------------------------------------- cells
   for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign occ[gi] = count_ff > CNT_W'(gi);

      skq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .descending  (desc_ff),
         .occ         (occ[gi]),
         .right_occ   ((gi == CAPACITY - 1) ? 1'b0 : occ[(gi + 1) % CAPACITY]),
         .left_p      ((gi == 0) ? 1'b1 : p[(gi + CAPACITY - 1) % CAPACITY]),
         .right_keq   ((gi == CAPACITY - 1) ? 1'b0 : keq[(gi + 1) % CAPACITY]),
         .cmp_entry   (entry_type'{key: req_data.key, tag: req_data.tag}),
         .ins_entry   (ins_entry),
         .left_entry  (cell_entry[(gi + CAPACITY - 1) % CAPACITY]),
         .right_entry (cell_entry[(gi + 1) % CAPACITY]),
         .entry       (cell_entry[gi]),
         .p_o         (p[gi]),
         .keq_o       (keq[gi]),
         .hit_o       (hit[gi]),
         .sel_o       (sel[gi])
      );
   end

   // one-hot select of the last equal key or of the tail entry
   always_comb begin
      hit_any   = 1'b0;
      sel_any   = 1'b0;
      sel_entry = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_any   = hit_any | hit[i];
         sel_any   = sel_any | sel[i];
         sel_entry = sel_entry | (cell_entry[i] & {$bits(entry_type){sel[i]}});
      end
   end

   // ---------------------------------------------------------------- result
   always_comb begin
      rsp_data_in.status  = STATUS_MISS;
      rsp_data_in.out_key = '0;
      rsp_data_in.out_tag = '0;
      count_in            = count_ff;
      case (req_ff.req_type)
         OP_INSERT: begin
            if (full) begin
               rsp_data_in.status = STATUS_FULL;
            end else begin
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.out_key = req_ff.key;
               rsp_data_in.out_tag = req_ff.tag;
               count_in            = count_ff + 1'b1;
            end
         end
         OP_REMOVE: begin
            if (hit_any) begin
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.out_key = req_ff.key;
               rsp_data_in.out_tag = req_ff.tag;
               count_in            = count_ff - 1'b1;
            end
         end
         OP_FIND: begin
            if (sel_any) begin
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.out_key = req_ff.key;
               rsp_data_in.out_tag = sel_entry.tag;
            end
         end
         OP_POP_HEAD: begin
            if (!empty) begin
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.out_key = cell_entry[0].key;
               rsp_data_in.out_tag = cell_entry[0].tag;
               count_in            = count_ff - 1'b1;
            end
         end
         OP_POP_TAIL: begin
            if (!empty) begin
               rsp_data_in.status  = STATUS_OK;
               rsp_data_in.out_key = sel_entry.key;
               rsp_data_in.out_tag = sel_entry.tag;
               count_in            = count_ff - 1'b1;
            end
         end
         default: begin
            rsp_data_in.status = STATUS_MISS;
         end
      endcase
      rsp_data_in.count = COUNT_W'(count_in);
   end

   assign rsp_valid_in = commit | (rsp_valid_ff & rsp_stall);
   assign desc_in      = (csr_wr_en && empty) ? csr_wr_data : desc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         desc_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (commit) begin
            count_ff <= count_in;
         end
         desc_ff      <= desc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------- checks
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == FSM_EXEC))
      else $error("response raised without an execute cycle");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_one_remove_hit: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_EXEC |-> $onehot0(hit))
      else $error("remove matched more than one cell");

   a_one_select: assert property (@(posedge clock) disable iff (reset)
      state_ff == FSM_EXEC |-> $onehot0(sel))
      else $error("equal keys not contiguous or tail select broken");

   a_count_on_commit: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(commit)) |-> $stable(count_ff))
      else $error("fill count moved without a commit");

endmodule
